// ===== rtl/core/nge_pkg.sv =====
// Shared types and constants for the next greater element core.
// Holds the word formats, stack sizing and the command and status structs.
// No dependencies.
package nge_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);

	localparam logic signed [31:0] NOT_FOUND = -32'sd1;

	typedef struct packed {
		logic signed [31:0] value;
		logic               new_sequence;
	} item_word_t;

	typedef struct packed {
		logic signed [31:0] next_greater;
		logic               found;
		logic               overflow;
	} result_word_t;

	typedef struct packed {
		logic load;
		logic pop;
		logic finish;
	} nge_cmd_t;

	typedef struct packed {
		logic pop_ok;
		logic out_free;
	} nge_sts_t;

endpackage

// ===== rtl/core/nge_ctrl.sv =====
// Controller state machine for the next greater element core.
// Sequences load, pop and finish steps; depends on nge_pkg.
module nge_ctrl
	import nge_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  nge_sts_t sts,
	output nge_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// Pop until the stack is empty or its top is greater, then hand off the result.
				if (sts.pop_ok) begin
					cmd.pop = 1'b1;
				end else if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/nge_dp.sv =====
// Datapath for the next greater element core: stack memory, cached top,
// stack count and output register. Depends on nge_pkg.
module nge_dp
	import nge_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  nge_cmd_t     cmd,
	output nge_sts_t     sts,
	input  item_word_t   item,
	output logic         result_valid,
	input  logic         result_ready,
	output result_word_t result
);

	logic signed [31:0] stack_mem [STACK_DEPTH];
	logic signed [31:0] top_q;
	logic signed [31:0] value_q;
	logic [CNT_W-1:0]   count_q;
	logic               out_valid_q;
	result_word_t       out_q;

	logic             not_empty;
	logic             full;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] wr_idx;
	logic [CNT_W-1:0] below_top;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign below_top = count_q - CNT_W'(2);
	assign rd_idx    = below_top[IDX_W-1:0];
	assign wr_idx    = count_q[IDX_W-1:0];

	assign sts.pop_ok   = not_empty && (top_q <= value_q);
	assign sts.out_free = !out_valid_q || result_ready;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// The top entry is cached in top_q; the memory holds every entry, the top included.
	always_ff @(posedge clk) begin
		if (cmd.finish && !full) begin
			stack_mem[wr_idx] <= value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			top_q <= stack_mem[rd_idx];
		end else if (cmd.finish && !full) begin
			top_q <= value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= item.value;
		end
		if (cmd.finish) begin
			out_q.next_greater <= not_empty ? top_q : NOT_FOUND;
			out_q.found        <= not_empty;
			out_q.overflow     <= full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && item.new_sequence) begin
				count_q <= '0;
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
			end else if (cmd.finish && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/next_greater_element_core.sv =====
// Next greater element core built on a monotonic stack.
// Instantiates nge_ctrl and nge_dp; depends on nge_pkg.
//
// Usage: words arrive on the item channel (valid/ready) in reverse array
// order, last element first. Setting new_sequence on a word empties the stack
// before that word is handled, which starts a new array. For every word the
// core returns exactly one result word on the result channel (valid/ready):
// the nearest strictly greater value seen earlier in the sequence, or -1 with
// found low when there is none. When the stack already holds STACK_DEPTH
// entries after popping, the word is not stored and overflow is set.
//
// Steps: an accepted word goes through a load step, a pop step for each stack
// entry it pops, and a finish step that waits while the output register still
// holds an unaccepted result. The pop rate is set by the single read port of
// the stack memory, which refills the cached top entry once per cycle. Each
// value is popped at most once, and the next word is taken only after the
// finish step. The result is visible the cycle after the finish step.
//
// Reset empties the stack and clears the result valid flag. A stalled receiver
// holds the result in the output register; the core still takes the next word
// and works on it, and waits only when that word's result needs the register.
module next_greater_element_core
	import nge_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  item_word_t   item,
	output logic         result_valid,
	input  logic         result_ready,
	output result_word_t result
);

	nge_cmd_t cmd;
	nge_sts_t sts;

	// State machine: decides when to load, pop and finish.
	nge_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Stack storage, comparison and the output register.
	nge_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

// ===== dv/nge_checker.sv =====
// Scoreboard for the next greater element core: watches both channels.
// Keeps a shadow monotonic stack, predicts each result word and compares it.
// Depends on nge_pkg.
module nge_checker
	import nge_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	input  logic         item_ready,
	input  item_word_t   item,
	input  logic         result_valid,
	input  logic         result_ready,
	input  result_word_t result,
	output int           mismatches,
	output int           pending
);

	logic signed [31:0] shadow_stack [STACK_DEPTH];
	int                 shadow_depth;
	result_word_t       expected_results [$];
	result_word_t       oldest;
	int                 results_seen;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t, result word %0d: %s", $time, results_seen, msg);
		mismatches++;
	endtask

	// Empties the stack on a start flag, pops every entry not greater than the
	// value, reports the new top and pushes the value if there is room left.
	function automatic result_word_t predict_next_greater(input item_word_t w);
		result_word_t r;
		if (w.new_sequence)
			shadow_depth = 0;
		while (shadow_depth > 0 && $signed(shadow_stack[shadow_depth - 1]) <= $signed(w.value))
			shadow_depth--;
		r.next_greater = NOT_FOUND;
		r.found = 1'b0;
		r.overflow = 1'b0;
		if (shadow_depth > 0) begin
			r.next_greater = shadow_stack[shadow_depth - 1];
			r.found = 1'b1;
		end
		if (shadow_depth < STACK_DEPTH) begin
			shadow_stack[shadow_depth] = w.value;
			shadow_depth++;
		end else begin
			r.overflow = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_depth = 0;
			mismatches = 0;
			results_seen = 0;
			expected_results.delete();
			pending <= 0;
		end else begin
			// A result can never belong to a word taken at the same edge,
			// so the result side is handled first.
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result word with no expectation waiting");
				end else begin
					oldest = expected_results.pop_front();
					if (result.next_greater !== oldest.next_greater)
						report_mismatch($sformatf("next_greater %0d, expected %0d",
							result.next_greater, oldest.next_greater));
					if (result.found !== oldest.found)
						report_mismatch($sformatf("found %b, expected %b",
							result.found, oldest.found));
					if (result.overflow !== oldest.overflow)
						report_mismatch($sformatf("overflow %b, expected %b",
							result.overflow, oldest.overflow));
				end
				results_seen++;
			end
			if (item_valid && item_ready)
				expected_results.push_back(predict_next_greater(item));
			pending <= expected_results.size();
		end
	end

endmodule

// ===== dv/tb_next_greater_element_core.sv =====
// Top of the next greater element core testbench: clock, reset and stimulus.
// Instantiates next_greater_element_core and nge_checker; depends on nge_pkg.
module tb_next_greater_element_core;
	import nge_pkg::*;

	typedef enum {SEQ_RANDOM, SEQ_NARROW, SEQ_FALLING, SEQ_RISING} seq_kind_t;

	localparam int RANDOM_WORDS  = 1250;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 2 * STACK_DEPTH + 16;
	localparam int LONG_HOLD     = 400;
	localparam int DIRECTED_N    = 20;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         item_valid = 1'b0;
	logic         item_ready;
	item_word_t   item = '0;
	logic         result_valid;
	logic         result_ready = 1'b0;
	result_word_t result;

	int mismatches;
	int pending;
	int random_sent = 0;
	int results_taken = 0;
	int cycle_count = 0;

	// Set per sequence; when high neither side inserts random idle cycles.
	logic no_idle = 1'b0;

	// Directed words: extremes of the value range, equal values (which are
	// popped), a greater element that is itself -1, a stack that carries
	// over without the start flag, and starts on a non-empty stack.
	int dir_value [DIRECTED_N] = '{
		5, 3, 3, 7, 32'sh8000_0000, 32'sh7fff_ffff, -1,
		-1, -5, -1, 0, 32'sh8000_0000, 32'sh8000_0000,
		32'sh7fff_ffff, 32'sh7fff_ffff, 0,
		32'sh8000_0000, 0, 1, -1
	};
	bit dir_start [DIRECTED_N] = '{
		1, 0, 0, 0, 0, 0, 0,
		1, 0, 0, 0, 0, 0,
		1, 0, 0,
		1, 1, 0, 0
	};

	next_greater_element_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	nge_checker CHK (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still expected", cycle_count, pending);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offers one word after a random gap and returns at the edge that takes it.
	// Valid is only lowered when a gap follows, so back-to-back words keep it
	// high without a second assignment in the same step.
	task automatic send_word(input int v, input bit start);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.value <= v;
		item.new_sequence <= start;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
	endtask

	// Stops offering words until the checker holds no expectation. The first
	// edge lets the word just taken show up in the pending count.
	task automatic drain_pause();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// One array, presented last element first. Noisy sequences get the odd
	// random value and the odd start flag in the middle; clean ones keep
	// their shape, which is what lets a long falling run fill the stack.
	task automatic run_sequence(input seq_kind_t kind, input int len, input bit start,
			input bit noisy);
		int v;
		bit s;
		case (kind)
			SEQ_FALLING: v = 32'sh4000_0000 + $urandom_range(0, 32'h3fff_ffff);
			SEQ_RISING:  v = 32'sh8000_0000 + $urandom_range(0, 32'h00ff_ffff);
			SEQ_NARROW:  v = $urandom_range(0, 16) - 8;
			default:     v = $urandom;
		endcase
		for (int i = 0; i < len; i++) begin
			s = (i == 0) ? start : (noisy && $urandom_range(0, 39) == 0);
			if (noisy && $urandom_range(0, 24) == 0)
				send_word($urandom, s);
			else
				send_word(v, s);
			random_sent++;
			case (kind)
				SEQ_FALLING: v = v - $urandom_range(1, 32'h0010_0000);
				SEQ_RISING:  v = v + $urandom_range(1, 32'h0010_0000);
				SEQ_NARROW:  v = $urandom_range(0, 16) - 8;
				default:     v = $urandom;
			endcase
		end
	endtask

	// Sender: reset, directed words, random sequences, then the verdict.
	initial begin
		int pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_N; i++)
			send_word(dir_value[i], dir_start[i]);
		drain_pause();

		while (random_sent < RANDOM_WORDS) begin
			pick = $urandom_range(0, 19);
			no_idle <= ($urandom_range(0, 7) == 0);
			if (pick == 19) begin
				// Runs from two words under to six words past the stack depth so that the
				// tail can overflow; a missing start flag makes it deeper still.
				run_sequence(SEQ_FALLING, $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 6),
					$urandom_range(0, 3) != 0, 1'b0);
			end else begin
				run_sequence(pick < 8 ? SEQ_RANDOM : pick < 12 ? SEQ_NARROW :
					pick < 17 ? SEQ_FALLING : SEQ_RISING,
					$urandom_range(1, 20), $urandom_range(0, 7) != 0, 1'b1);
			end
			if ($urandom_range(0, 24) == 0)
				drain_pause();
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Receiver: a random wait before each result word, and twice a long
	// hold-off while the sender keeps going, so the core backs up and drops
	// its input ready.
	initial begin
		int hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 3);
			if (results_taken == 150 || results_taken == 900)
				hold = LONG_HOLD;
			if (hold > 0) begin
				result_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			results_taken++;
		end
	end

endmodule
